FILE: rtl/salw_pkg.sv
package salw_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'h55;
	localparam int unsigned SYNC_NEEDED = 4;
	localparam logic [1:0] SYNC_LAST_RUN = 2'(SYNC_NEEDED - 1);

	typedef enum logic [2:0] {
		PH_SEEK    = 3'd0,
		PH_ADDR_LO = 3'd1,
		PH_ADDR_HI = 3'd2,
		PH_LEN_LO  = 3'd3,
		PH_LEN_HI  = 3'd4,
		PH_DATA    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_FRAME = 2'd0,
		KIND_BYTE  = 2'd1,
		KIND_EMPTY = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] write_address;
		logic [15:0] byte_offset;
		logic [7:0]  payload_byte;
		logic        last;
	} result_t;

endpackage

FILE: rtl/salw_byte_if.sv
interface salw_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

FILE: rtl/salw_result_if.sv
interface salw_result_if;
	logic                valid;
	logic                ready;
	salw_pkg::kind_t     kind;
	logic [15:0]         write_address;
	logic [15:0]         byte_offset;
	logic [7:0]          payload_byte;
	logic                last;

	modport source (
		output valid, output kind, output write_address, output byte_offset,
		output payload_byte, output last, input ready
	);
	modport sink (
		input valid, input kind, input write_address, input byte_offset,
		input payload_byte, input last, output ready
	);
endinterface

FILE: rtl/salw_parser.sv
module salw_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        stream_byte,
	output logic              has_result,
	output salw_pkg::result_t result
);

	salw_pkg::phase_t phase_q, phase_d;
	logic [1:0]       sync_run_q, sync_run_d;
	logic [15:0]      address_q, address_d;
	logic [7:0]       length_lo_q, length_lo_d;
	logic [15:0]      length_q, length_d;
	logic [15:0]      received_q, received_d;
	logic [15:0]      full_length;
	logic [16:0]      next_count;
	logic             is_sync;
	logic             fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= salw_pkg::PH_SEEK;
			sync_run_q  <= 2'd0;
			address_q   <= 16'd0;
			length_lo_q <= 8'd0;
			length_q    <= 16'd0;
			received_q  <= 16'd0;
		end else if (take) begin
			phase_q     <= phase_d;
			sync_run_q  <= sync_run_d;
			address_q   <= address_d;
			length_lo_q <= length_lo_d;
			length_q    <= length_d;
			received_q  <= received_d;
		end
	end

	assign is_sync     = (stream_byte == salw_pkg::SYNC_BYTE);
	assign full_length = {stream_byte, length_lo_q};
	assign next_count  = {1'b0, received_q} + 17'd1;
	assign fin         = (next_count == {1'b0, length_q});

	always_comb begin
		phase_d     = phase_q;
		sync_run_d  = sync_run_q;
		address_d   = address_q;
		length_lo_d = length_lo_q;
		length_d    = length_q;
		received_d  = received_q;
		has_result  = 1'b0;
		result      = '{kind: salw_pkg::KIND_FRAME, write_address: 16'd0,
			byte_offset: 16'd0, payload_byte: 8'd0, last: 1'b0};
		unique case (phase_q)
			salw_pkg::PH_ADDR_LO: begin
				// A sync byte where an address should start means the frame was lost.
				if (is_sync) begin
					phase_d    = salw_pkg::PH_SEEK;
					sync_run_d = 2'd1;
				end else begin
					address_d = {8'd0, stream_byte};
					phase_d   = salw_pkg::PH_ADDR_HI;
				end
			end
			salw_pkg::PH_ADDR_HI: begin
				address_d = {stream_byte, address_q[7:0]};
				phase_d   = salw_pkg::PH_LEN_LO;
			end
			salw_pkg::PH_LEN_LO: begin
				length_lo_d = stream_byte;
				phase_d     = salw_pkg::PH_LEN_HI;
			end
			salw_pkg::PH_LEN_HI: begin
				length_d   = full_length;
				received_d = 16'd0;
				if (full_length == 16'd0) begin
					phase_d           = salw_pkg::PH_ADDR_LO;
					has_result        = 1'b1;
					result.kind          = salw_pkg::KIND_EMPTY;
					result.write_address = address_q;
					result.last          = 1'b1;
				end else begin
					phase_d = salw_pkg::PH_DATA;
				end
			end
			salw_pkg::PH_DATA: begin
				received_d = next_count[15:0];
				if (fin) begin
					phase_d = salw_pkg::PH_ADDR_LO;
				end
				has_result           = 1'b1;
				result.kind          = salw_pkg::KIND_BYTE;
				result.write_address = address_q;
				result.byte_offset   = received_q;
				result.payload_byte  = stream_byte;
				result.last          = fin;
			end
			default: begin
				// Seeking sync; the unused phase codes land here as well.
				phase_d = salw_pkg::PH_SEEK;
				if (is_sync) begin
					if (sync_run_q == salw_pkg::SYNC_LAST_RUN) begin
						sync_run_d  = 2'd0;
						phase_d     = salw_pkg::PH_ADDR_LO;
						has_result  = 1'b1;
						result.kind = salw_pkg::KIND_FRAME;
					end else begin
						sync_run_d = sync_run_q + 2'd1;
					end
				end else begin
					sync_run_d = 2'd0;
				end
			end
		endcase
	end

endmodule

FILE: rtl/sync_address_length_write_deframer_unit.sv
// Channel  Dir  Payload                                             Handshake
// stream   in   stream_byte[7:0]                                    valid/ready
// result   out  kind[1:0] write_address[15:0] byte_offset[15:0]     valid/ready
//               payload_byte[7:0] last
//
// One byte is taken per cycle while the skid register is empty. The parser is combinational logic that feeds the result
// register, so a result is shown the cycle after its byte is accepted when that register is free.
// arst_n clears the parser to sync seeking and empties both output stages.
// A two-entry output stage (result register plus skid register) lets a byte be
// accepted while a result waits; stream.ready falls only once the skid is full.
module sync_address_length_write_deframer_unit (
	input  logic          clk,
	input  logic          arst_n,
	salw_byte_if.sink     stream,
	salw_result_if.source result
);

	salw_pkg::result_t new_result;
	salw_pkg::result_t out_q;
	salw_pkg::result_t skid_q;
	logic              has_result;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              take;
	logic              push;
	logic              pop;

	assign stream.ready = !skid_valid_q;
	assign take         = stream.valid && stream.ready;
	assign push         = take && has_result;
	assign pop          = out_valid_q && result.ready;

	salw_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.stream_byte (stream.stream_byte),
		.has_result  (has_result),
		.result      (new_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= push;
				end else begin
					out_valid_q <= push;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Payload stages need no reset; they follow the valid flags above.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= new_result;
			end else begin
				out_q <= new_result;
			end
		end else if (!out_valid_q) begin
			out_q <= new_result;
		end else if (push) begin
			skid_q <= new_result;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.kind          = out_q.kind;
	assign result.write_address = out_q.write_address;
	assign result.byte_offset   = out_q.byte_offset;
	assign result.payload_byte  = out_q.payload_byte;
	assign result.last          = out_q.last;

endmodule

FILE: verif/write_record_checker.sv
`timescale 1ns / 100ps

module write_record_checker (
	input  logic   clk,
	input  logic   arst_n,
	salw_byte_if   stream,
	salw_result_if result,
	output int     fail_count,
	output int     waiting_count,
	output int     frame_count,
	output int     payload_count,
	output int     empty_count
);
	import salw_pkg::*;

	phase_t      parse_phase;
	logic [1:0]  sync_run;
	logic [15:0] rec_address;
	logic [15:0] rec_length;
	logic [15:0] rec_taken;
	result_t     pending_writes[$];
	int          fails;
	int          frames;
	int          payloads;
	int          empties;

	function automatic void expect_write(input result_t r);
		pending_writes = {pending_writes, r};
	endfunction

	// Works out what one accepted stream item should produce, if anything.
	task automatic parse_stream_byte(input logic [7:0] b);
		result_t r;
		logic    fin;
		r = '0;
		case (parse_phase)
			PH_ADDR_LO: begin
				if (b == SYNC_BYTE) begin
					parse_phase = PH_SEEK;
					sync_run = 2'd1;
				end else begin
					rec_address = {8'h00, b};
					parse_phase = PH_ADDR_HI;
				end
			end
			PH_ADDR_HI: begin
				rec_address[15:8] = b;
				parse_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				rec_length = {8'h00, b};
				parse_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				rec_length[15:8] = b;
				rec_taken = '0;
				if (rec_length == '0) begin
					parse_phase = PH_ADDR_LO;
					r.kind = KIND_EMPTY;
					r.write_address = rec_address;
					r.last = 1'b1;
					expect_write(r);
				end else begin
					parse_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				fin = (rec_taken + 16'd1) == rec_length;
				r.kind = KIND_BYTE;
				r.write_address = rec_address;
				r.byte_offset = rec_taken;
				r.payload_byte = b;
				r.last = fin;
				rec_taken = rec_taken + 16'd1;
				if (fin) begin
					parse_phase = PH_ADDR_LO;
				end
				expect_write(r);
			end
			default: begin
				parse_phase = PH_SEEK;
				if (b != SYNC_BYTE) begin
					sync_run = '0;
				end else if (sync_run == SYNC_LAST_RUN) begin
					sync_run = '0;
					parse_phase = PH_ADDR_LO;
					r.kind = KIND_FRAME;
					expect_write(r);
				end else begin
					sync_run = sync_run + 2'd1;
				end
			end
		endcase
	endtask

	function automatic void report_field(string field, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			fails++;
			$error("%s: expected %0h, got %0h", field, want, got);
		end
	endfunction

	task automatic check_write();
		result_t want;
		if (pending_writes.size() == 0) begin
			fails++;
			$error("result with nothing expected: kind %0d address %0h offset %0h data %0h",
				result.kind, result.write_address, result.byte_offset,
				result.payload_byte);
		end else begin
			want = pending_writes.pop_front();
			report_field("kind", want.kind, result.kind);
			report_field("write_address", want.write_address, result.write_address);
			report_field("byte_offset", want.byte_offset, result.byte_offset);
			report_field("payload_byte", want.payload_byte, result.payload_byte);
			report_field("last", want.last, result.last);
			case (want.kind)
				KIND_FRAME: frames++;
				KIND_BYTE:  payloads++;
				default:    empties++;
			endcase
		end
	endtask

	// Results are compared before the new item is parsed: a result accepted on an
	// edge always belongs to an item accepted on an earlier edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_phase = PH_SEEK;
			sync_run = '0;
			rec_address = '0;
			rec_length = '0;
			rec_taken = '0;
			pending_writes.delete();
			fails = 0;
			frames = 0;
			payloads = 0;
			empties = 0;
			fail_count <= 0;
			waiting_count <= 0;
			frame_count <= 0;
			payload_count <= 0;
			empty_count <= 0;
		end else begin
			if (result.valid && result.ready) begin
				check_write();
			end
			if (stream.valid && stream.ready) begin
				parse_stream_byte(stream.stream_byte);
			end
			fail_count <= fails;
			waiting_count <= pending_writes.size();
			frame_count <= frames;
			payload_count <= payloads;
			empty_count <= empties;
		end
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import salw_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;

	// Opening sequence: a broken sync run, a full sync, a sync byte in the address
	// slot followed by three more, an empty write to the top address, a two-byte
	// record carrying the sync value as data, a record with the sync value as its
	// address high byte, and finally a sync byte in the address slot.
	localparam logic [7:0] OPENING [27] = '{
		SYNC_BYTE, SYNC_BYTE, 8'h00,
		SYNC_BYTE, SYNC_BYTE, SYNC_BYTE, SYNC_BYTE,
		SYNC_BYTE,
		SYNC_BYTE, SYNC_BYTE, SYNC_BYTE,
		8'hFF, 8'hFF, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h02, 8'h00, 8'hFF, SYNC_BYTE,
		8'hAA, SYNC_BYTE, 8'h01, 8'h00, 8'h00,
		SYNC_BYTE
	};

	logic clk;
	logic arst_n;

	salw_byte_if   stream_if ();
	salw_result_if result_if ();

	int fail_count;
	int waiting_count;
	int frame_count;
	int payload_count;
	int empty_count;

	int items_sent;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int seek_run;

	sync_address_length_write_deframer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if)
	);

	write_record_checker record_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.stream        (stream_if),
		.result        (result_if),
		.fail_count    (fail_count),
		.waiting_count (waiting_count),
		.frame_count   (frame_count),
		.payload_count (payload_count),
		.empty_count   (empty_count)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(2_000_000 * CLK_PERIOD);
		$display("sync_address_length_write_deframer_unit regression: fail");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			stream_if.valid <= 1'b0;
			@(posedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.stream_byte <= b;
		@(posedge clk);
		while (!stream_if.ready) @(posedge clk);
		items_sent++;
	endtask

	function automatic logic [7:0] data_byte();
		if ($urandom_range(5) == 0) begin
			return SYNC_BYTE;
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == SYNC_BYTE);
		return b;
	endfunction

	function automatic logic [15:0] record_length();
		int pick;
		pick = $urandom_range(99);
		if (pick < 20) begin
			return 16'd0;
		end else if (pick < 90) begin
			return 16'($urandom_range(8, 1));
		end else if (pick < 98) begin
			return 16'($urandom_range(40, 9));
		end
		return 16'($urandom_range(300, 256));
	endfunction

	// The parser sits in sync seeking with seek_run sync bytes already counted.
	// Noise never holds a full run, so the frame starts exactly where intended.
	task automatic send_sync();
		if ($urandom_range(99) < 30) begin
			repeat ($urandom_range(4, 1)) send_byte(plain_byte());
			if ($urandom_range(1)) begin
				repeat ($urandom_range(3, 1)) send_byte(SYNC_BYTE);
				send_byte(plain_byte());
			end
			seek_run = 0;
		end
		repeat (SYNC_NEEDED - seek_run) send_byte(SYNC_BYTE);
		seek_run = 0;
	endtask

	task automatic send_record(input logic [15:0] addr, input logic [15:0] len,
			output bit dropped);
		send_byte(addr[7:0]);
		dropped = (addr[7:0] == SYNC_BYTE);
		if (dropped) begin
			seek_run = 1;
			return;
		end
		send_byte(addr[15:8]);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		for (int i = 0; i < len; i++) send_byte(data_byte());
	endtask

	// One frame of one to four records; now and then a record is cut short by a
	// sync byte in its address slot. A whole frame closes the same way.
	task automatic send_frame();
		logic [15:0] addr;
		bit          dropped;
		send_sync();
		repeat ($urandom_range(4, 1)) begin
			addr[15:8] = 8'($urandom_range(255));
			addr[7:0] = ($urandom_range(99) < 8) ? SYNC_BYTE : plain_byte();
			send_record(addr, record_length(), dropped);
			if (dropped) begin
				return;
			end
		end
		send_byte(SYNC_BYTE);
		seek_run = 1;
	endtask

	task automatic wait_for_results();
		stream_if.valid <= 1'b0;
		@(posedge clk);
		wait (waiting_count == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int target;
		bit dropped;
		arst_n = 1'b0;
		stream_if.valid = 1'b0;
		stream_if.stream_byte = '0;
		result_if.ready = 1'b0;
		items_sent = 0;
		hold_requests = 0;
		seek_run = 0;
		send_idle_pct = 19;
		recv_idle_pct = 70;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (OPENING[i]) send_byte(OPENING[i]);
		seek_run = 1;
		while (items_sent < 150) send_frame();
		wait_for_results();

		send_idle_pct = 70;
		recv_idle_pct = 19;
		while (items_sent < 280) send_frame();
		wait_for_results();

		// The receiver holds off while a long record streams in, so the output
		// stage fills and the block has to stall its input.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests++;
		send_sync();
		send_record(16'h1234, 16'd40, dropped);
		// A record whose address high byte and length low byte carry the sync value.
		send_record(16'h550F, 16'h0055, dropped);
		send_byte(SYNC_BYTE);
		seek_run = 1;
		target = items_sent + 80;
		while (items_sent < target) send_frame();
		wait_for_results();

		$display("Sent %0d stream items over three stall mixes and a long output hold-off.",
			items_sent);
		$display("Checked %0d frame starts, %0d payload bytes and %0d empty writes; %0d failures.",
			frame_count, payload_count, empty_count, fail_count);
		if (fail_count == 0 && waiting_count == 0) begin
			$display("sync_address_length_write_deframer_unit regression: pass");
		end else begin
			$display("sync_address_length_write_deframer_unit regression: fail");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/salw_pkg.sv
rtl/salw_byte_if.sv
rtl/salw_result_if.sv
rtl/salw_parser.sv
rtl/sync_address_length_write_deframer_unit.sv
verif/write_record_checker.sv
verif/tb_top.sv
